FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold at a clock edge out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/msp_pkg.sv
package msp_pkg;

    localparam int SYSEX_COUNT_BITS = 16;

    typedef logic [SYSEX_COUNT_BITS-1:0] cnt_t;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_VOICE  = 3'd1,
        KIND_COMMON = 3'd2,
        KIND_RT     = 3'd3,
        KIND_SYSEX  = 3'd4
    } kind_t;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOICE_MASK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMON_MASK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RT_MASK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_SEL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SYSEX_EN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SYSEX_LIMIT = 3'd5;

    localparam logic [7:0] ST_MIN       = 8'h80;
    localparam logic [7:0] ST_VOICE_MAX = 8'hEF;
    localparam logic [7:0] ST_SOX       = 8'hF0;
    localparam logic [7:0] ST_EOX       = 8'hF7;
    localparam logic [7:0] ST_RT_MIN    = 8'hF8;
    localparam logic [4:0] CHAN_ALL     = 5'd16;

    typedef struct packed {
        logic [7:0]  voice_mask;
        logic [7:0]  common_mask;
        logic [7:0]  rt_mask;
        logic [4:0]  chan_sel;
        logic        sysex_en;
        logic [15:0] sysex_limit;
    } cfg_t;

    typedef struct packed {
        logic        captured;
        logic        msg_ready;
        kind_t       msg_kind;
        logic [7:0]  status_out;
        logic [6:0]  first_data;
        logic [6:0]  second_data;
        logic [1:0]  msg_length;
        logic [15:0] sysex_length;
        logic        sysex_error;
        logic        sysex_busy;
        logic [15:0] sysex_write_index;
    } result_t;

    function automatic logic [1:0] status_len(logic [7:0] s);
        logic [1:0] len;
        len = 2'd0;
        if (s >= ST_RT_MIN) begin
            len = 2'd1;
        end
        else if (s >= ST_SOX) begin
            case (s[3:0])
                4'h1:    len = 2'd2;
                4'h2:    len = 2'd3;
                4'h3:    len = 2'd2;
                4'h6:    len = 2'd1;
                default: len = 2'd0;
            endcase
        end
        else if (s >= ST_MIN) begin
            len = (s[7:4] == 4'hC || s[7:4] == 4'hD) ? 2'd2 : 2'd3;
        end
        return len;
    endfunction

    function automatic logic [15:0] low16(cnt_t v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

endpackage

FILE: hw/rtl/msp_cfg.sv
module msp_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [msp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data,
    output msp_pkg::cfg_t                 cfg,
    output logic                          clr_sysex
);
    import msp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next  = cfg_reg;
        clr_sysex = 1'b0;
        if (wr)
        begin
            case (cfg_index)
                CFG_VOICE_MASK:  cfg_next.voice_mask  = cfg_data[7:0];
                CFG_COMMON_MASK: cfg_next.common_mask = cfg_data[7:0];
                CFG_RT_MASK:     cfg_next.rt_mask     = cfg_data[7:0];
                CFG_CHAN_SEL:    cfg_next.chan_sel    = cfg_data[4:0];
                CFG_SYSEX_EN:
                begin
                    cfg_next.sysex_en = cfg_data[0];
                    clr_sysex         = 1'b1;
                end
                CFG_SYSEX_LIMIT:
                begin
                    cfg_next.sysex_limit = cfg_data;
                    clr_sysex            = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.voice_mask  <= 8'hFF;
            cfg_reg.common_mask <= 8'hFF;
            cfg_reg.rt_mask     <= 8'hFF;
            cfg_reg.chan_sel    <= CHAN_ALL;
            cfg_reg.sysex_en    <= 1'b0;
            cfg_reg.sysex_limit <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hw/rtl/msp_parse.sv
module msp_parse (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [7:0]       byte_in,
    input  msp_pkg::cfg_t    cfg,
    input  logic             clr_sysex,
    output msp_pkg::result_t res
);
    import msp_pkg::*;

    logic [7:0] mb0_reg, mb0_next;
    logic [6:0] mb1_reg, mb1_next;
    logic [6:0] mb2_reg, mb2_next;
    logic [7:0] rt_reg, rt_next;
    logic [1:0] exp_reg, exp_next;
    logic [1:0] rem_reg, rem_next;
    kind_t      pend_reg, pend_next;
    kind_t      parsed_reg, parsed_next;
    logic       run_ok_reg, run_ok_next;
    logic       in_sysex_reg, in_sysex_next;
    cnt_t       cnt_reg, cnt_next;
    cnt_t       total_reg, total_next;

    logic       cap;
    logic       rdy;
    logic       err;
    cnt_t       widx;
    logic [1:0] blen;
    logic [1:0] rem_eff;
    logic [1:0] idx;
    logic       pass;
    logic [1:0] olen;
    logic [7:0] ost;

    assign blen = status_len(byte_in);

    always_comb
    begin
        mb0_next      = mb0_reg;
        mb1_next      = mb1_reg;
        mb2_next      = mb2_reg;
        rt_next       = rt_reg;
        exp_next      = exp_reg;
        rem_next      = rem_reg;
        pend_next     = pend_reg;
        parsed_next   = parsed_reg;
        run_ok_next   = run_ok_reg;
        in_sysex_next = in_sysex_reg;
        cnt_next      = cnt_reg;
        total_next    = total_reg;
        cap           = 1'b0;
        rdy           = 1'b0;
        err           = 1'b0;
        widx          = '0;
        pass          = 1'b0;
        rem_eff       = rem_reg;
        idx           = 2'd0;

        if (byte_in >= ST_RT_MIN)
        begin
            cap = cfg.rt_mask[~byte_in[2:0]];
            if (cap)
            begin
                parsed_next = KIND_RT;
                rt_next     = byte_in;
            end
            rdy = cap;
        end
        else if (byte_in >= ST_MIN)
        begin
            run_ok_next = 1'b0;
            pend_next   = KIND_NONE;
            rem_next    = 2'd0;
            exp_next    = 2'd0;
            if (byte_in == ST_EOX)
            begin
                if (in_sysex_reg)
                begin
                    in_sysex_next = 1'b0;
                    if (cfg.sysex_en)
                    begin
                        parsed_next = KIND_SYSEX;
                        cap         = 1'b1;
                        total_next  = cnt_reg;
                        rdy         = 1'b1;
                    end
                end
                else
                begin
                    err        = 1'b1;
                    total_next = '0;
                    cnt_next   = '0;
                end
            end
            else
            begin
                if (in_sysex_reg)
                begin
                    in_sysex_next = 1'b0;
                    err           = 1'b1;
                    total_next    = cnt_reg;
                end
                if (byte_in == ST_SOX)
                begin
                    in_sysex_next = 1'b1;
                    cnt_next      = '0;
                    pend_next     = KIND_SYSEX;
                    cap           = cfg.sysex_en;
                end
                else
                begin
                    if (byte_in <= ST_VOICE_MAX)
                    begin
                        pend_next = KIND_VOICE;
                        pass = (cfg.chan_sel == CHAN_ALL) ||
                               ({1'b0, byte_in[3:0]} == cfg.chan_sel);
                        cap  = pass && cfg.voice_mask[~byte_in[6:4]];
                    end
                    else
                    begin
                        pend_next = KIND_COMMON;
                        cap = (blen != 2'd0) && cfg.common_mask[~byte_in[2:0]];
                    end
                    if (cap)
                    begin
                        exp_next = blen;
                        rem_next = blen - 2'd1;
                        mb0_next = byte_in;
                        if (blen == 2'd1)
                        begin
                            parsed_next = KIND_COMMON;
                            rdy         = 1'b1;
                        end
                    end
                end
            end
        end
        else if (in_sysex_reg)
        begin
            if (cfg.sysex_en)
            begin
                if (cfg.sysex_limit == 16'd0)
                begin
                    cap  = 1'b1;
                    widx = cnt_reg;
                    if (cnt_reg != '1)
                    begin
                        cnt_next = cnt_reg + cnt_t'(1);
                    end
                end
                else if (32'(cnt_reg) >= 32'(cfg.sysex_limit))
                begin
                    err           = 1'b1;
                    in_sysex_next = 1'b0;
                    total_next    = cnt_reg;
                end
                else
                begin
                    cap      = 1'b1;
                    widx     = cnt_reg;
                    cnt_next = cnt_reg + cnt_t'(1);
                end
            end
        end
        else
        begin
            if (run_ok_reg)
            begin
                rem_eff     = status_len(mb0_reg) - 2'd1;
                run_ok_next = 1'b0;
            end
            rem_next = rem_eff;
            if (rem_eff != 2'd0)
            begin
                idx = exp_reg - rem_eff;
                case (idx)
                    2'd0:    mb0_next = byte_in;
                    2'd1:    mb1_next = byte_in[6:0];
                    2'd2:    mb2_next = byte_in[6:0];
                    default: ;
                endcase
                rem_next = rem_eff - 2'd1;
                cap      = 1'b1;
                if (rem_next == 2'd0)
                begin
                    parsed_next = pend_reg;
                    if (pend_reg == KIND_VOICE)
                    begin
                        run_ok_next = 1'b1;
                    end
                    rdy = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        ost  = 8'd0;
        olen = 2'd0;
        if (parsed_next == KIND_VOICE || parsed_next == KIND_COMMON)
        begin
            ost  = mb0_next;
            olen = status_len(mb0_next);
        end
        else if (parsed_next == KIND_RT)
        begin
            ost  = rt_next;
            olen = 2'd1;
        end
        res.captured          = cap;
        res.msg_ready         = rdy;
        res.msg_kind          = parsed_next;
        res.status_out        = ost;
        res.first_data        = (olen >= 2'd2) ? mb1_next : 7'd0;
        res.second_data       = (olen == 2'd3) ? mb2_next : 7'd0;
        res.msg_length        = olen;
        res.sysex_length      = low16(total_next);
        res.sysex_error       = err;
        res.sysex_busy        = in_sysex_next;
        res.sysex_write_index = low16(widx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mb0_reg      <= 8'd0;
            mb1_reg      <= 7'd0;
            mb2_reg      <= 7'd0;
            rt_reg       <= 8'd0;
            exp_reg      <= 2'd0;
            rem_reg      <= 2'd0;
            pend_reg     <= KIND_NONE;
            parsed_reg   <= KIND_NONE;
            run_ok_reg   <= 1'b0;
            in_sysex_reg <= 1'b0;
            cnt_reg      <= '0;
            total_reg    <= '0;
        end
        else if (clr_sysex)
        begin
            cnt_reg   <= '0;
            total_reg <= '0;
        end
        else if (advance)
        begin
            mb0_reg      <= mb0_next;
            mb1_reg      <= mb1_next;
            mb2_reg      <= mb2_next;
            rt_reg       <= rt_next;
            exp_reg      <= exp_next;
            rem_reg      <= rem_next;
            pend_reg     <= pend_next;
            parsed_reg   <= parsed_next;
            run_ok_reg   <= run_ok_next;
            in_sysex_reg <= in_sysex_next;
            cnt_reg      <= cnt_next;
            total_reg    <= total_next;
        end
    end

endmodule

FILE: hw/rtl/midi_stream_parser_core.sv
// MIDI byte-stream parser: one received byte per item in, one result per item out, at
// a sustained rate of one item per clock while out_ready stays high (input register,
// then a single pass of parse logic into the result register). Running status, message
// filtering by type masks and channel, and SysEx tracking are resolved in that one pass;
// the result register lets the next byte enter while a result waits on out_ready.
// Captured SysEx data bytes come with sysex_write_index for an external buffer.
// Configuration writes (cfg_index 0..5) are taken every cycle and must be issued only
// while no item is in flight; writing the SysEx enable or limit clears the SysEx counts.
`include "assert_macros.svh"

module midi_stream_parser_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    data_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          captured,
    output logic                          msg_ready,
    output logic [2:0]                    msg_kind,
    output logic [7:0]                    status_out,
    output logic [6:0]                    first_data,
    output logic [6:0]                    second_data,
    output logic [1:0]                    msg_length,
    output logic [15:0]                   sysex_length,
    output logic                          sysex_error,
    output logic                          sysex_busy,
    output logic [15:0]                   sysex_write_index,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [msp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data
);
    import msp_pkg::*;

    cfg_t       cfg;
    logic       clr_sysex;
    result_t    res;
    logic       advance;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    res_reg;

    msp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .clr_sysex (clr_sysex)
    );

    msp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .byte_in   (in_byte_reg),
        .cfg       (cfg),
        .clr_sysex (clr_sysex),
        .res       (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
        begin
            in_valid_next = in_valid;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= data_byte;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid         = out_valid_reg;
    assign captured          = res_reg.captured;
    assign msg_ready         = res_reg.msg_ready;
    assign msg_kind          = res_reg.msg_kind;
    assign status_out        = res_reg.status_out;
    assign first_data        = res_reg.first_data;
    assign second_data       = res_reg.second_data;
    assign msg_length        = res_reg.msg_length;
    assign sysex_length      = res_reg.sysex_length;
    assign sysex_error       = res_reg.sysex_error;
    assign sysex_busy        = res_reg.sysex_busy;
    assign sysex_write_index = res_reg.sysex_write_index;

    `ASSERT_CLK(a_ready_has_kind, clk, rst_n, out_valid_reg && res_reg.msg_ready |-> res_reg.msg_kind != KIND_NONE, "message ready with no kind")
    `ASSERT_CLK(a_widx_in_sysex, clk, rst_n, out_valid_reg && res_reg.sysex_write_index != 16'd0 |-> res_reg.captured && res_reg.sysex_busy, "write index outside captured sysex data")
    `ASSERT_CLK(a_in_hold, clk, rst_n, in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg), "pending input item lost")
    `ASSERT_NEVER(a_cfg_in_flight, clk, rst_n, clr_sysex && advance, "config write while an item is in flight")

endmodule

FILE: test/midi_stream_parser_core_tb.sv
module midi_stream_parser_core_tb;
    import msp_pkg::*;

    typedef struct packed {
        logic [7:0] b;
        bit         fixed;
        result_t    want;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic [7:0]           data_byte = 8'h00;
    logic                 out_ready = 1'b1;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_VOICE_MASK;
    logic [15:0]          cfg_data = 16'h0000;

    logic        in_ready, out_valid, cfg_ready;
    logic        captured, msg_ready, sysex_error, sysex_busy;
    logic [2:0]  msg_kind;
    logic [7:0]  status_out;
    logic [6:0]  first_data, second_data;
    logic [1:0]  msg_length;
    logic [15:0] sysex_length, sysex_write_index;

    // parser mirror: settings
    logic [7:0]  voice_en_bits = 8'hFF;
    logic [7:0]  common_en_bits = 8'hFF;
    logic [7:0]  rt_en_bits = 8'hFF;
    logic [4:0]  chan_pick = CHAN_ALL;
    logic        sx_en = 1'b0;
    logic [15:0] sx_limit = 16'd0;

    // parser mirror: state
    logic [7:0]  hold_bytes [3] = '{8'h00, 8'h00, 8'h00};
    logic [7:0]  rt_last = 8'h00;
    logic [1:0]  want_len = 2'd0;
    logic [1:0]  left_len = 2'd0;
    kind_t       open_kind = KIND_NONE;
    kind_t       done_kind = KIND_NONE;
    logic        run_ok = 1'b0;
    logic        sx_open = 1'b0;
    cnt_t        sx_count = '0;
    cnt_t        sx_total = '0;

    result_t     pending_results [$];
    result_t     got, want;
    bit          quiet = 1'b0;
    int          items = 0;
    int          mismatches = 0;
    int          n_settings = 0;
    int          n_voice = 0, n_common = 0, n_rt = 0, n_sysex = 0, n_sx_err = 0;

    midi_stream_parser_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .data_byte         (data_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .captured          (captured),
        .msg_ready         (msg_ready),
        .msg_kind          (msg_kind),
        .status_out        (status_out),
        .first_data        (first_data),
        .second_data       (second_data),
        .msg_length        (msg_length),
        .sysex_length      (sysex_length),
        .sysex_error       (sysex_error),
        .sysex_busy        (sysex_busy),
        .sysex_write_index (sysex_write_index),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #7_200_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [1:0] bytes_in_msg(logic [7:0] s);
        if (s[7:3] == 5'b11111)
        begin
            return 2'd1;
        end
        if (s[7:4] == 4'hF)
        begin
            if (s[3:0] == 4'h2)
            begin
                return 2'd3;
            end
            if (s[3:0] == 4'h1 || s[3:0] == 4'h3)
            begin
                return 2'd2;
            end
            return (s[3:0] == 4'h6) ? 2'd1 : 2'd0;
        end
        if (s[7])
        begin
            return (s[7:5] == 3'b110) ? 2'd2 : 2'd3;
        end
        return 2'd0;
    endfunction

    function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
        case (idx)
            CFG_VOICE_MASK:  voice_en_bits = v[7:0];
            CFG_COMMON_MASK: common_en_bits = v[7:0];
            CFG_RT_MASK:     rt_en_bits = v[7:0];
            CFG_CHAN_SEL:    chan_pick = v[4:0];
            CFG_SYSEX_EN:
            begin
                sx_en = v[0];
                sx_count = '0;
                sx_total = '0;
            end
            CFG_SYSEX_LIMIT:
            begin
                sx_limit = v;
                sx_count = '0;
                sx_total = '0;
            end
            default: ;
        endcase
    endfunction

    function automatic result_t parse_midi(logic [7:0] b);
        result_t    r;
        logic [1:0] slot;
        logic [1:0] len;
        r = '0;
        if (b >= ST_RT_MIN)
        begin
            r.captured = rt_en_bits[3'(4'd15 - b[3:0])];
            if (r.captured)
            begin
                done_kind = KIND_RT;
                rt_last = b;
            end
            r.msg_ready = r.captured;
        end
        else if (b[7])
        begin
            run_ok = 1'b0;
            open_kind = KIND_NONE;
            left_len = 2'd0;
            want_len = 2'd0;
            if (b == ST_EOX)
            begin
                if (sx_open)
                begin
                    sx_open = 1'b0;
                    if (sx_en)
                    begin
                        done_kind = KIND_SYSEX;
                        r.captured = 1'b1;
                        r.msg_ready = 1'b1;
                        sx_total = sx_count;
                    end
                end
                else
                begin
                    r.sysex_error = 1'b1;
                    sx_total = '0;
                    sx_count = '0;
                end
            end
            else
            begin
                if (sx_open)
                begin
                    sx_open = 1'b0;
                    r.sysex_error = 1'b1;
                    sx_total = sx_count;
                end
                if (b == ST_SOX)
                begin
                    sx_open = 1'b1;
                    sx_count = '0;
                    open_kind = KIND_SYSEX;
                    r.captured = sx_en;
                end
                else
                begin
                    if (b <= ST_VOICE_MAX)
                    begin
                        open_kind = KIND_VOICE;
                        r.captured = (chan_pick == CHAN_ALL || chan_pick == {1'b0, b[3:0]})
                                     && voice_en_bits[3'(4'd15 - b[7:4])];
                    end
                    else
                    begin
                        open_kind = KIND_COMMON;
                        r.captured = (bytes_in_msg(b) != 2'd0) && common_en_bits[3'd7 - b[2:0]];
                    end
                    if (r.captured)
                    begin
                        want_len = bytes_in_msg(b);
                        left_len = want_len - 2'd1;
                        hold_bytes[0] = b;
                        if (want_len == 2'd1)
                        begin
                            done_kind = KIND_COMMON;
                            r.msg_ready = 1'b1;
                        end
                    end
                end
            end
        end
        else if (sx_open)
        begin
            if (sx_en)
            begin
                if (sx_limit == 16'd0)
                begin
                    r.captured = 1'b1;
                    r.sysex_write_index = sx_count[15:0];
                    if (sx_count != '1)
                    begin
                        sx_count = sx_count + cnt_t'(1);
                    end
                end
                else if (sx_count >= sx_limit)
                begin
                    r.sysex_error = 1'b1;
                    sx_open = 1'b0;
                    sx_total = sx_count;
                end
                else
                begin
                    r.captured = 1'b1;
                    r.sysex_write_index = sx_count[15:0];
                    sx_count = sx_count + cnt_t'(1);
                end
            end
        end
        else
        begin
            if (run_ok)
            begin
                left_len = bytes_in_msg(hold_bytes[0]) - 2'd1;
                run_ok = 1'b0;
            end
            if (left_len != 2'd0)
            begin
                slot = want_len - left_len;
                if (slot != 2'd3)
                begin
                    hold_bytes[slot] = b;
                end
                left_len = left_len - 2'd1;
                r.captured = 1'b1;
                if (left_len == 2'd0)
                begin
                    done_kind = open_kind;
                    if (done_kind == KIND_VOICE)
                    begin
                        run_ok = 1'b1;
                    end
                    r.msg_ready = 1'b1;
                end
            end
        end

        r.msg_kind = done_kind;
        if (done_kind == KIND_VOICE || done_kind == KIND_COMMON)
        begin
            len = bytes_in_msg(hold_bytes[0]);
            r.status_out = hold_bytes[0];
            r.msg_length = len;
            if (len >= 2'd2)
            begin
                r.first_data = hold_bytes[1][6:0];
            end
            if (len == 2'd3)
            begin
                r.second_data = hold_bytes[2][6:0];
            end
        end
        else if (done_kind == KIND_RT)
        begin
            r.status_out = rt_last;
            r.msg_length = 2'd1;
        end
        r.sysex_length = sx_total[15:0];
        r.sysex_busy = sx_open;
        return r;
    endfunction

    function automatic result_t lit(logic cap, logic rdy, kind_t k, logic [7:0] st,
                                    logic [6:0] d1, logic [6:0] d2, logic [1:0] len);
        result_t r;
        r = '0;
        r.captured = cap;
        r.msg_ready = rdy;
        r.msg_kind = k;
        r.status_out = st;
        r.first_data = d1;
        r.second_data = d2;
        r.msg_length = len;
        return r;
    endfunction

    function automatic string describe_result(result_t r);
        return $sformatf({"cap=%0b rdy=%0b kind=%0d st=%02h d1=%02h d2=%02h len=%0d ",
                          "sxlen=%0d err=%0b busy=%0b widx=%0d"},
                         r.captured, r.msg_ready, r.msg_kind, r.status_out, r.first_data,
                         r.second_data, r.msg_length, r.sysex_length, r.sysex_error,
                         r.sysex_busy, r.sysex_write_index);
    endfunction

    function automatic logic [7:0] data7();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'h7F;
            default: return 8'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic logic [7:0] rt_byte();
        return 8'($urandom_range(ST_RT_MIN, 8'hFF));
    endfunction

    task automatic send_byte(logic [7:0] b, bit use_lit = 1'b0, result_t lit_res = '0);
        result_t r;
        if (!quiet && $urandom_range(0, 24) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        do @(posedge clk); while (!in_ready);
        r = parse_midi(b);
        pending_results.push_back(use_lit ? lit_res : r);
        items++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic send_message(int sx_max);
        int         pick;
        int         n;
        logic [7:0] st;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            st = 8'($urandom_range(ST_MIN, ST_VOICE_MAX));
            send_byte(st);
            repeat ($urandom_range(1, 4))
            begin
                for (int i = 1; i < int'(bytes_in_msg(st)); i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        send_byte(rt_byte());
                    end
                    send_byte(data7());
                end
            end
        end
        else if (pick < 55)
        begin
            case ($urandom_range(0, 5))
                0:       st = 8'hF1;
                1:       st = 8'hF2;
                2:       st = 8'hF3;
                3:       st = 8'hF6;
                4:       st = 8'hF4;
                default: st = 8'hF5;
            endcase
            send_byte(st);
            n = (bytes_in_msg(st) == 2'd0) ? $urandom_range(0, 2) : int'(bytes_in_msg(st)) - 1;
            repeat (n) send_byte(data7());
        end
        else if (pick < 65)
        begin
            send_byte(rt_byte());
        end
        else if (pick < 82)
        begin
            send_byte(ST_SOX);
            repeat ($urandom_range(0, sx_max))
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    send_byte(rt_byte());
                end
                send_byte(data7());
            end
            case ($urandom_range(0, 9))
                0:       send_byte(8'($urandom_range(ST_MIN, 8'hF6)));
                1:       ;
                default: send_byte(ST_EOX);
            endcase
        end
        else if (pick < 92)
        begin
            // truncated message, or an end of SysEx with nothing open
            st = 8'($urandom_range(ST_MIN, ST_VOICE_MAX));
            send_byte(st);
            if (bytes_in_msg(st) == 2'd3 && $urandom_range(0, 1) == 1)
            begin
                send_byte(data7());
            end
            if ($urandom_range(0, 3) == 0)
            begin
                send_byte(ST_EOX);
            end
        end
        else
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_stream(int count, int sx_max);
        int mark;
        mark = items;
        while (items - mark < count)
        begin
            send_message(sx_max);
            if ($urandom_range(0, 149) == 0)
            begin
                drain();
            end
        end
    endtask

    task automatic run_phase(logic [7:0] vm, logic [7:0] cm, logic [7:0] rm, logic [4:0] ch,
                             logic en, logic [15:0] lim, int count);
        logic [CFG_IDX_W-1:0] order [6];
        logic [15:0]          vals [6];
        order = '{CFG_VOICE_MASK, CFG_COMMON_MASK, CFG_RT_MASK, CFG_CHAN_SEL,
                  CFG_SYSEX_EN, CFG_SYSEX_LIMIT};
        vals = '{{8'h00, vm}, {8'h00, cm}, {8'h00, rm}, {11'd0, ch}, {15'd0, en}, lim};
        drain();
        for (int i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= order[i];
            cfg_data <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            apply_setting(order[i], vals[i]);
        end
        cfg_valid <= 1'b0;
        n_settings++;
        send_stream(count, (lim == 16'd0 || lim > 16'd10) ? 12 : int'(lim) + 2);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 14) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got = {captured, msg_ready, msg_kind, status_out, first_data, second_data,
                   msg_length, sysex_length, sysex_error, sysex_busy, sysex_write_index};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result: %s", describe_result(got));
                end
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at %0t", $realtime);
                        $display("  expected %s", describe_result(want));
                        $display("  actual   %s", describe_result(got));
                    end
                end
            end
            if (got.msg_ready)
            begin
                case (got.msg_kind)
                    KIND_VOICE:  n_voice++;
                    KIND_COMMON: n_common++;
                    KIND_RT:     n_rt++;
                    KIND_SYSEX:  n_sysex++;
                    default: ;
                endcase
            end
            if (got.sysex_error)
            begin
                n_sx_err++;
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t dir_rows [$];
        dir_rows.push_back({8'h00, 1'b1,
                            lit(1'b0, 1'b0, KIND_NONE, 8'h00, 7'h00, 7'h00, 2'd0)});
        dir_rows.push_back({8'h90, 1'b1,
                            lit(1'b1, 1'b0, KIND_NONE, 8'h00, 7'h00, 7'h00, 2'd0)});
        dir_rows.push_back({8'h3C, 1'b1,
                            lit(1'b1, 1'b0, KIND_NONE, 8'h00, 7'h00, 7'h00, 2'd0)});
        dir_rows.push_back({8'h7F, 1'b1,
                            lit(1'b1, 1'b1, KIND_VOICE, 8'h90, 7'h3C, 7'h7F, 2'd3)});
        dir_rows.push_back({8'h40, 1'b0, result_t'('0)});
        dir_rows.push_back({8'h00, 1'b0, result_t'('0)});
        dir_rows.push_back({8'hF8, 1'b1,
                            lit(1'b1, 1'b1, KIND_RT, 8'hF8, 7'h00, 7'h00, 2'd1)});
        dir_rows.push_back({8'hC5, 1'b0, result_t'('0)});
        dir_rows.push_back({8'h7F, 1'b0, result_t'('0)});
        dir_rows.push_back({8'hE3, 1'b0, result_t'('0)});
        dir_rows.push_back({8'h01, 1'b0, result_t'('0)});
        dir_rows.push_back({8'hFF, 1'b0, result_t'('0)});
        dir_rows.push_back({8'h7F, 1'b0, result_t'('0)});
        dir_rows.push_back({8'hF1, 1'b0, result_t'('0)});
        dir_rows.push_back({8'h55, 1'b0, result_t'('0)});
        dir_rows.push_back({8'hF2, 1'b0, result_t'('0)});
        dir_rows.push_back({8'h01, 1'b0, result_t'('0)});
        dir_rows.push_back({8'h02, 1'b0, result_t'('0)});
        dir_rows.push_back({8'hF6, 1'b0, result_t'('0)});
        dir_rows.push_back({8'hF4, 1'b0, result_t'('0)});
        dir_rows.push_back({ST_EOX, 1'b0, result_t'('0)});
        dir_rows.push_back({ST_SOX, 1'b0, result_t'('0)});
        dir_rows.push_back({8'h11, 1'b0, result_t'('0)});
        dir_rows.push_back({ST_EOX, 1'b0, result_t'('0)});
        dir_rows.push_back({ST_SOX, 1'b0, result_t'('0)});
        dir_rows.push_back({8'h90, 1'b0, result_t'('0)});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        foreach (dir_rows[i])
        begin
            send_byte(dir_rows[i].b, dir_rows[i].fixed, dir_rows[i].want);
        end
        send_stream(150, 12);

        run_phase(8'h00, 8'h00, 8'h00, 5'd0, 1'b1, 16'd1, 180);
        run_phase(8'hFF, 8'hFF, 8'hFF, CHAN_ALL, 1'b1, 16'd0, 180);
        run_phase(8'($urandom), 8'($urandom), 8'($urandom), 5'd15, 1'b1,
                  16'($urandom_range(2, 6)), 180);
        run_phase(8'($urandom), 8'($urandom), 8'($urandom), 5'd31, 1'b0, 16'hFFFF, 150);
        run_phase(8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom_range(0, 16)), 1'b1,
                  16'hFFFF, 180);
        run_phase(8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom), 1'($urandom),
                  16'($urandom_range(0, 8)), 180);

        // last part: no random idling on either side
        quiet = 1'b1;
        run_phase(8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom_range(0, 16)), 1'b1,
                  16'd4, 150);

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d MIDI bytes under %0d register settings plus reset defaults.",
                 items, n_settings);
        $display("Completed: %0d voice, %0d common, %0d real-time, %0d SysEx; %0d SysEx errors.",
                 n_voice, n_common, n_rt, n_sysex, n_sx_err);
        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
